### hdl/eli_pkg.sv
// eased linear interpolation: curve selector codes and rom builder functions
// used by eased_linear_interpolation_core; depends on nothing
package eli_pkg;

    // curve selector codes
    localparam logic [3:0] CURVE_LIN      = 4'd0;
    localparam logic [3:0] CURVE_INVLIN   = 4'd1;
    localparam logic [3:0] CURVE_QUAD     = 4'd2;
    localparam logic [3:0] CURVE_INVQUAD  = 4'd3;
    localparam logic [3:0] CURVE_SINE     = 4'd4;
    localparam logic [3:0] CURVE_INVSINE  = 4'd5;
    localparam logic [3:0] CURVE_CIRC     = 4'd6;
    localparam logic [3:0] CURVE_INVCIRC  = 4'd7;
    localparam logic [3:0] CURVE_BUMP     = 4'd8;

    // table values are q1.30
    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

    // horner denominators 210 156 110 72 42 20 6 of the sine series, as
    // ceil(2^40 / d), exact for dividends below 2^32
    function automatic logic [63:0] sine_recip(input int k);
        logic [63:0] m;
        case (k)
            0:       m = 64'd5235769657;
            1:       m = 64'd7048151461;
            2:       m = 64'd9995560253;
            3:       m = 64'd15270994831;
            4:       m = 64'd26178848281;
            5:       m = 64'd54975581389;
            default: m = 64'd183251937963;
        endcase
        return m;
    endfunction

    // sin(i * pi/2 / 2^a) in q1.30, evaluated at elaboration
    function automatic logic [31:0] sine_entry(input int i, input int a);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] q;
        logic [63:0] v;
        logic [127:0] prod;
        x = (PI_HALF_Q30 * 64'(i) + ((64'd1 << a) >> 1)) >> a;
        x2 = (x * x) >> 30;
        t = Q30_ONE;
        for (int k = 0; k < 7; k++) begin
            prod = 128'((x2 * t) >> 30) * 128'(sine_recip(k));
            q = prod[103:40];
            t = (q >= Q30_ONE) ? 64'd0 : Q30_ONE - q;
        end
        v = (x * t) >> 30;
        if (v > Q30_ONE) begin
            v = Q30_ONE;
        end
        return v[31:0];
    endfunction

    // integer square root, bit by bit
    function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] bitv;
        n = n_in;
        res = 64'd0;
        bitv = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (n >= res + bitv) begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // sqrt(1 - x^2) in q1.30 with x = i / 2^a
    function automatic logic [31:0] circ_entry(input int i, input int a);
        logic [63:0] xi;
        logic [63:0] r;
        xi = 64'(i) << (30 - a);
        r = isqrt64((64'd1 << 60) - xi * xi);
        return r[31:0];
    endfunction

endpackage

### hdl/eased_linear_interpolation_core.sv
// eased linear interpolation core: six stage pipeline with sine and circle roms
// depends on eli_pkg for curve codes and rom contents
//
// Takes one item per clock when nothing stalls and returns one result per item.
// The ratio is clamped to one, shaped by the selected curve (linear, quadratic,
// quarter sine, circle, rise-and-fall bump, or the inverse of each but the bump;
// unknown codes act as linear), and used as weight w in start*w + end*(1-w),
// rounded half up and saturated to signed q8.8. The sine and circle curves come
// from two roms of 2^TABLE_ADDR_BITS+1 entries, built at elaboration, read at two
// neighboring entries and interpolated linearly. Each stage holds its item when
// the next stage is full and stalled, so a stall neither drops nor repeats an
// item, and empty stages keep filling meanwhile.
module eased_linear_interpolation_core
    import eli_pkg::*;
#(
    parameter int TABLE_ADDR_BITS = 10,
    parameter int RATIO_FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_start_value,
    input  logic signed [15:0] i_end_value,
    input  logic [16:0]        i_ratio,
    input  logic [3:0]         i_func,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_blended_value
);

    localparam int A    = TABLE_ADDR_BITS;
    localparam int F    = RATIO_FRAC_BITS;
    localparam int TAB  = (1 << A) + 1;
    localparam int RB   = F + 1;
    localparam int CW   = (RB > 17) ? RB : 17;
    localparam int FB   = 32 - A;
    localparam int DW   = 33;
    localparam int IPW  = DW + FB + 1;
    localparam int BPW  = 2 * F + 4;
    localparam int MW   = 16 + RB + 1;
    localparam int SW   = MW + 1;
    localparam int RW   = SW - F;

    localparam logic [RB-1:0]  ONE      = RB'(1) << F;
    localparam logic [RB-1:0]  HALF     = RB'(1) << (F - 1);
    localparam logic [CW-1:0]  ONE_W    = CW'(1) << F;
    localparam logic [A:0]     TAB_LAST = (A + 1)'(1) << A;
    localparam logic signed [IPW-1:0] SPAN_HALF = IPW'(1) << (FB - 1);
    localparam logic [IPW-1:0] RND30    = IPW'(1) << (29 - F);
    localparam logic signed [RW-1:0] SAT_HI = RW'(32767);
    localparam logic signed [RW-1:0] SAT_LO = -RW'(32768);

    // rom contents
    logic [31:0] sine_rom [TAB];
    logic [31:0] circ_rom [TAB];

    for (genvar g = 0; g < TAB; g++) begin : g_rom
        localparam logic [31:0] SINE_V = sine_entry(g, A);
        localparam logic [31:0] CIRC_V = circ_entry(g, A);
        assign sine_rom[g] = SINE_V;
        assign circ_rom[g] = CIRC_V;
    end

    // stage valids and advance enables
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic en1, en2, en3, en4, en5, en6;

    assign en6 = !r_v6 || !i_stall;
    assign en5 = !r_v5 || en6;
    assign en4 = !r_v4 || en5;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign o_stall = !en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
            if (en6) r_v6 <= r_v5;
        end
    end

    // stage 1: clamp, table address, squares, rom read
    logic [CW-1:0]   ratio_w;
    logic [RB-1:0]   rc;
    logic [DW-1:0]   pos;
    logic [A:0]      idx0;
    logic [A:0]      idx1;
    logic            lower;
    logic [F-1:0]    s_in;
    logic            use_sine;

    assign ratio_w  = CW'(i_ratio);
    assign rc       = (ratio_w > ONE_W) ? ONE : RB'(ratio_w);
    assign pos      = DW'(rc) << (32 - F);
    assign idx0     = pos[DW-1:FB];
    assign idx1     = (idx0 == TAB_LAST) ? idx0 : idx0 + (A + 1)'(1);
    assign lower    = rc < HALF;
    assign s_in     = lower ? F'(rc) : F'(rc - HALF);
    assign use_sine = (i_func == CURVE_SINE) || (i_func == CURVE_INVSINE);

    logic signed [15:0] r_s1_start, r_s1_end;
    logic [3:0]         r_s1_sel;
    logic [2*RB-1:0]    r_s1_sq;
    logic [2*F-1:0]     r_s1_ss;
    logic [F-1:0]       r_s1_s;
    logic               r_s1_lower;
    logic [31:0]        r_s1_ra, r_s1_rb;
    logic [FB-1:0]      r_s1_frac;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_start <= i_start_value;
            r_s1_end   <= i_end_value;
            r_s1_sel   <= i_func;
            r_s1_sq    <= (2 * RB)'(rc) * (2 * RB)'(rc);
            r_s1_ss    <= (2 * F)'(s_in) * (2 * F)'(s_in);
            r_s1_s     <= s_in;
            r_s1_lower <= lower;
            r_s1_frac  <= pos[FB-1:0];
            r_s1_ra    <= use_sine ? sine_rom[idx0] : circ_rom[idx0];
            r_s1_rb    <= use_sine ? sine_rom[idx1] : circ_rom[idx1];
        end
    end

    // stage 2: round squares, interpolation product
    logic signed [DW-1:0] diff;
    assign diff = $signed({1'b0, r_s1_rb}) - $signed({1'b0, r_s1_ra});

    logic signed [15:0]    r_s2_start, r_s2_end;
    logic [3:0]            r_s2_sel;
    logic [RB-1:0]         r_s2_quad;
    logic [RB-1:0]         r_s2_q;
    logic [F-1:0]          r_s2_s;
    logic                  r_s2_lower;
    logic [31:0]           r_s2_ra;
    logic signed [IPW-1:0] r_s2_iprod;

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_start <= r_s1_start;
            r_s2_end   <= r_s1_end;
            r_s2_sel   <= r_s1_sel;
            r_s2_quad  <= RB'(((2 * RB + 1)'(r_s1_sq) + (2 * RB + 1)'(HALF)) >> F);
            r_s2_q     <= RB'(((2 * F + 1)'(r_s1_ss) + (2 * F + 1)'(HALF)) >> F);
            r_s2_s     <= r_s1_s;
            r_s2_lower <= r_s1_lower;
            r_s2_ra    <= r_s1_ra;
            r_s2_iprod <= IPW'(diff) * $signed({1'b0, (IPW - 1)'(r_s1_frac)});
        end
    end

    // stage 3: finish table value, bump product
    logic signed [IPW-1:0] istep;
    logic [IPW-1:0]        ival;
    logic [IPW-1:0]        iround;
    logic [F+1:0]          bump_t;

    assign istep  = (r_s2_iprod + SPAN_HALF) >>> FB;
    assign ival   = IPW'(r_s2_ra) + IPW'(istep);
    assign iround = (ival + RND30) >> (30 - F);
    assign bump_t = (F + 2)'(3) * (F + 2)'(ONE) - ((F + 2)'(r_s2_s) << 2);

    logic signed [15:0] r_s3_start, r_s3_end;
    logic [3:0]         r_s3_sel;
    logic [RB-1:0]      r_s3_quad;
    logic [RB-1:0]      r_s3_lut;
    logic               r_s3_lower;
    logic [BPW-1:0]     r_s3_bprod;

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_s3_start <= r_s2_start;
            r_s3_end   <= r_s2_end;
            r_s3_sel   <= r_s2_sel;
            r_s3_quad  <= r_s2_quad;
            r_s3_lut   <= (iround > IPW'(ONE)) ? ONE : RB'(iround);
            r_s3_lower <= r_s2_lower;
            r_s3_bprod <= BPW'(r_s2_q) * BPW'(bump_t);
        end
    end

    // stage 4: finish bump, pick the weight
    logic [BPW-1:0] bump_v;
    logic [RB-1:0]  bump_c;
    logic [RB-1:0]  bump_w;
    logic [RB-1:0]  w_sel;

    assign bump_v = ((r_s3_bprod << 2) + BPW'(HALF)) >> F;
    assign bump_c = (bump_v > BPW'(ONE)) ? ONE : RB'(bump_v);
    assign bump_w = r_s3_lower ? bump_c : ONE - bump_c;

    always_comb begin
        case (r_s3_sel)
            CURVE_LIN:     w_sel = r_s3_quad == r_s3_quad ? RB'(0) : RB'(0);
            default:       w_sel = RB'(0);
        endcase
    end

    logic [RB-1:0] r_s1_rc, r_s2_rc, r_s3_rc;
    always_ff @(posedge i_clk) begin
        if (en1) r_s1_rc <= rc;
        if (en2) r_s2_rc <= r_s1_rc;
        if (en3) r_s3_rc <= r_s2_rc;
    end

    logic [RB-1:0] w_pick;
    always_comb begin
        case (r_s3_sel)
            CURVE_INVLIN:  w_pick = ONE - r_s3_rc;
            CURVE_QUAD:    w_pick = r_s3_quad;
            CURVE_INVQUAD: w_pick = ONE - r_s3_quad;
            CURVE_SINE:    w_pick = r_s3_lut;
            CURVE_INVSINE: w_pick = ONE - r_s3_lut;
            CURVE_CIRC:    w_pick = r_s3_lut;
            CURVE_INVCIRC: w_pick = ONE - r_s3_lut;
            CURVE_BUMP:    w_pick = bump_w;
            default:       w_pick = r_s3_rc | w_sel;
        endcase
    end

    logic signed [15:0] r_s4_start, r_s4_end;
    logic [RB-1:0]      r_s4_w;

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_s4_start <= r_s3_start;
            r_s4_end   <= r_s3_end;
            r_s4_w     <= w_pick;
        end
    end

    // stage 5: weight products
    logic signed [MW-1:0] r_s5_aw, r_s5_bw;

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r_s5_aw <= MW'(r_s4_start) * $signed({1'b0, (MW - 1)'(r_s4_w)});
            r_s5_bw <= MW'(r_s4_end) * $signed({1'b0, (MW - 1)'(ONE - r_s4_w)});
        end
    end

    // stage 6: sum, round half up, saturate
    logic signed [SW-1:0] sum;
    logic signed [RW-1:0] res;

    assign sum = SW'(r_s5_aw) + SW'(r_s5_bw) + $signed({1'b0, (SW - 1)'(HALF)});
    assign res = RW'(sum >>> F);

    logic signed [15:0] r_s6_val;

    always_ff @(posedge i_clk) begin
        if (en6) begin
            if (res > SAT_HI) begin
                r_s6_val <= 16'sh7fff;
            end else if (res < SAT_LO) begin
                r_s6_val <= -16'sh8000;
            end else begin
                r_s6_val <= 16'(res);
            end
        end
    end

    assign o_valid         = r_v6;
    assign o_blended_value = r_s6_val;

endmodule

### sim/tb_eased_linear_interpolation_core.sv
// testbench for eased_linear_interpolation_core: directed table plus random items,
// each result checked against an in-bench curve and blend predictor; depends on eli_pkg
`timescale 1ns / 100ps

module tb_eased_linear_interpolation_core;
    import eli_pkg::*;

    localparam int ADDR_BITS = 10;
    localparam int FRAC_BITS = 16;
    localparam int TAB_LEN   = (1 << ADDR_BITS) + 1;
    localparam logic [63:0] W_ONE = 64'd1 << FRAC_BITS;
    localparam int CYCLE_LIMIT = 200000;
    localparam int N_RANDOM = 800;

    typedef struct packed {
        logic signed [15:0] start_v;
        logic signed [15:0] end_v;
        logic [16:0]        ratio;
        logic [3:0]         func;
        logic               has_exp;
        logic signed [15:0] exp_v;
    } stim_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic signed [15:0] i_start_value = '0;
    logic signed [15:0] i_end_value = '0;
    logic [16:0] i_ratio = '0;
    logic [3:0] i_func = CURVE_LIN;
    logic o_valid;
    logic i_stall = 1'b1;
    logic signed [15:0] o_blended_value;

    logic [31:0] sine_tab [TAB_LEN];
    logic [31:0] circ_tab [TAB_LEN];
    logic signed [15:0] blend_queue [$];
    int errors = 0;
    int cycles = 0;
    bit hold_off = 1'b0;

    eased_linear_interpolation_core #(
        .TABLE_ADDR_BITS(ADDR_BITS),
        .RATIO_FRAC_BITS(FRAC_BITS)
    ) i_dut (.*);

    always #5 i_clk = ~i_clk;

    // square root by bit pairs
    function automatic logic [63:0] root64(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] b;
        n = n_in;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // fill sine and circle tables in q1.30
    task automatic build_tables();
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] q;
        logic [63:0] v;
        logic [63:0] xi;
        logic [63:0] dv [7];
        dv = '{64'd210, 64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
        for (int i = 0; i < TAB_LEN; i++) begin
            x = (64'd1686629713 * 64'(i) + ((64'd1 << ADDR_BITS) >> 1)) >> ADDR_BITS;
            x2 = (x * x) >> 30;
            t = 64'd1 << 30;
            for (int k = 0; k < 7; k++) begin
                q = ((x2 * t) >> 30) / dv[k];
                t = (q >= (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - q;
            end
            v = (x * t) >> 30;
            if (v > (64'd1 << 30)) v = 64'd1 << 30;
            sine_tab[i] = v[31:0];
            xi = 64'(i) << (30 - ADDR_BITS);
            v = root64((64'd1 << 60) - xi * xi);
            circ_tab[i] = v[31:0];
        end
    endtask

    // interpolated table read, result with FRAC_BITS fraction bits
    function automatic logic [63:0] table_read(input bit use_sine, input logic [63:0] r);
        logic [63:0] span;
        logic [63:0] p;
        logic [63:0] idx;
        logic [63:0] idx1;
        logic [63:0] frac;
        logic [63:0] v;
        logic [63:0] e0;
        logic [63:0] e1;
        span = 64'd1 << (32 - ADDR_BITS);
        p = r << (32 - FRAC_BITS);
        idx = p >> (32 - ADDR_BITS);
        frac = p & (span - 1);
        if (idx > TAB_LEN - 1) idx = TAB_LEN - 1;
        idx1 = (idx + 1 < TAB_LEN) ? idx + 1 : idx;
        e0 = use_sine ? sine_tab[idx] : circ_tab[idx];
        e1 = use_sine ? sine_tab[idx1] : circ_tab[idx1];
        v = (e0 * (span - frac) + e1 * frac + (span >> 1)) >> (32 - ADDR_BITS);
        v = (v + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
        return (v > W_ONE) ? W_ONE : v;
    endfunction

    function automatic logic [63:0] bump_rise(input logic [63:0] s);
        logic [63:0] q;
        logic [63:0] v;
        q = (s * s + (W_ONE >> 1)) >> FRAC_BITS;
        v = (4 * q * (3 * W_ONE - 4 * s) + (W_ONE >> 1)) >> FRAC_BITS;
        return (v > W_ONE) ? W_ONE : v;
    endfunction

    // expected blended value for one item
    function automatic logic signed [15:0] predict_blend(input logic signed [15:0] a,
            input logic signed [15:0] b, input logic [16:0] ratio, input logic [3:0] fn);
        logic [63:0] r;
        logic [63:0] w;
        longint sum;
        longint res;
        r = (ratio > W_ONE) ? W_ONE : 64'(ratio);
        case (fn)
            CURVE_INVLIN:  w = W_ONE - r;
            CURVE_QUAD:    w = (r * r + (W_ONE >> 1)) >> FRAC_BITS;
            CURVE_INVQUAD: w = W_ONE - ((r * r + (W_ONE >> 1)) >> FRAC_BITS);
            CURVE_SINE:    w = table_read(1'b1, r);
            CURVE_INVSINE: w = W_ONE - table_read(1'b1, r);
            CURVE_CIRC:    w = table_read(1'b0, r);
            CURVE_INVCIRC: w = W_ONE - table_read(1'b0, r);
            CURVE_BUMP:    w = (r < (W_ONE >> 1)) ? bump_rise(r)
                                                  : W_ONE - bump_rise(r - (W_ONE >> 1));
            default:       w = r;
        endcase
        if (w > W_ONE) w = W_ONE;
        sum = longint'(a) * longint'(w) + longint'(b) * longint'(W_ONE - w)
            + longint'(W_ONE >> 1);
        res = sum >>> FRAC_BITS;
        if (res > 32767) res = 32767;
        if (res < -32768) res = -32768;
        return res[15:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    // send one item after a random gap, valid stays high between items without a gap
    task automatic send_item(input stim_t s);
        logic signed [15:0] ev;
        int gap;
        gap = $urandom_range(0, 6);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        ev = predict_blend(s.start_v, s.end_v, s.ratio, s.func);
        if (s.has_exp && ev !== s.exp_v) begin
            report_mismatch($sformatf("directed row disagrees with predictor %0d", ev));
        end
        i_valid <= 1'b1;
        i_start_value <= s.start_v;
        i_end_value <= s.end_v;
        i_ratio <= s.ratio;
        i_func <= s.func;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        blend_queue.push_back(s.has_exp ? s.exp_v : ev);
    endtask

    // random item, mostly within range, some ratios above one
    function automatic stim_t random_item();
        stim_t s;
        s.start_v = 16'($urandom);
        s.end_v = 16'($urandom);
        s.ratio = ($urandom_range(0, 9) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
        s.func = 4'($urandom);
        s.has_exp = 1'b0;
        s.exp_v = '0;
        return s;
    endfunction

    // receiver: random wait before each result, one long hold-off on request
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            if (hold_off) begin
                i_stall <= 1'b1;
                repeat (60) @(posedge i_clk);
                hold_off = 1'b0;
            end
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    // compare results in order
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (blend_queue.size() == 0) begin
                report_mismatch($sformatf("unexpected result %0d", o_blended_value));
            end else begin
                if (o_blended_value !== blend_queue[0]) begin
                    report_mismatch($sformatf("blended_value %0d, expected %0d",
                                              o_blended_value, blend_queue[0]));
                end
                void'(blend_queue.pop_front());
            end
        end
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("eased_linear_interpolation_core test failed");
            $finish;
        end
    end

    // main sequence
    initial begin
        stim_t rows [$];
        build_tables();
        // extremes, every curve, clamp, unknown selector, last table entry
        rows = '{
            '{16'sh7fff, -16'sh8000, 17'd65536, CURVE_LIN,     1'b1, 16'sh7fff},
            '{16'sh7fff, -16'sh8000, 17'd0,     CURVE_LIN,     1'b1, -16'sh8000},
            '{16'sh7fff, -16'sh8000, 17'h1ffff, CURVE_LIN,     1'b1, 16'sh7fff},
            '{16'sh0100, 16'sh0200,  17'd0,     CURVE_INVLIN,  1'b1, 16'sh0100},
            '{16'sh0100, 16'sh0200,  17'd32768, CURVE_QUAD,    1'b0, 16'sh0},
            '{-16'sh8000, 16'sh7fff, 17'd40000, CURVE_INVQUAD, 1'b0, 16'sh0},
            '{16'sh1234, 16'sh0000,  17'd65536, CURVE_SINE,    1'b1, 16'sh1234},
            '{16'sh1234, -16'sh0100, 17'd12345, CURVE_SINE,    1'b0, 16'sh0},
            '{16'sh1234, -16'sh0100, 17'd65535, CURVE_INVSINE, 1'b0, 16'sh0},
            '{16'sh4000, 16'sh0000,  17'd0,     CURVE_CIRC,    1'b1, 16'sh4000},
            '{16'sh4000, 16'sh0000,  17'd65536, CURVE_CIRC,    1'b0, 16'sh0},
            '{16'sh4000, -16'sh4000, 17'd65500, CURVE_INVCIRC, 1'b0, 16'sh0},
            '{16'sh0100, 16'sh0000,  17'd32767, CURVE_BUMP,    1'b0, 16'sh0},
            '{16'sh0100, 16'sh0000,  17'd32768, CURVE_BUMP,    1'b0, 16'sh0},
            '{16'sh0100, 16'sh0000,  17'd65536, CURVE_BUMP,    1'b0, 16'sh0},
            '{16'sh0100, 16'sh0000,  17'd1000,  CURVE_BUMP,    1'b0, 16'sh0},
            '{16'sh0100, 16'sh0300,  17'd65536, 4'd9,          1'b1, 16'sh0100},
            '{-16'sh0001, 16'sh0002, 17'd30000, 4'd15,         1'b0, 16'sh0},
            '{-16'sh8000, -16'sh8000, 17'd21845, CURVE_SINE,   1'b0, 16'sh0},
            '{16'sh7fff, 16'sh7fff,  17'd50000, CURVE_CIRC,    1'b0, 16'sh0}
        };
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (rows[k]) send_item(rows[k]);
        for (int n = 0; n < N_RANDOM; n++) begin
            // long hold-off while items keep coming
            if (n == 400) hold_off = 1'b1;
            send_item(random_item());
        end
        i_valid <= 1'b0;
        while (blend_queue.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("eased_linear_interpolation_core test passed");
        end else begin
            $display("eased_linear_interpolation_core test failed");
        end
        $finish;
    end

endmodule
